// File: rtl/pfba_pkg.sv
// Shared types, constants and helpers for the page frame bitmap allocator.
// Used by pfba_ctrl, pfba_dp, the top level and the checker; depends on nothing.
package pfba_pkg;

  localparam int FRAME_COUNT = 8192;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int BYTE_W      = 8;
  localparam int BIT_IX_W    = $clog2(BYTE_W);
  localparam int MAP_BYTES   = FRAME_COUNT / BYTE_W;
  localparam int MAP_FRAMES  = MAP_BYTES * BYTE_W;
  localparam int MAP_AW      = $clog2(MAP_BYTES);

  localparam int ADDR_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 14;
  localparam int CFG_IDX_W   = 1;

  // Frame number of a byte address, and the same with one spare bit for round-up.
  localparam int FRAME_W     = ADDR_W - PAGE_SHIFT;
  // Byte index into the bitmap as derived from a 32-bit bound, before clamping.
  localparam int SB_W        = FRAME_W + 1 - BIT_IX_W;

  localparam logic [ADDR_W-1:0] HIGH_BOUND_RESET = ADDR_W'(33554432);
  localparam logic [BYTE_W-1:0] BYTE_FULL        = '1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND = CFG_IDX_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_OOM          = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_CHK,
    S_POST
  } state_t;

  typedef struct packed {
    logic clr;       // write one zero byte of the clearing sweep
    logic accept;    // latch a new request
    logic scan;      // allocate scan in progress
    logic free_chk;  // check and clear the bit of a free request
    logic post;      // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic out_busy;
  } sts_t;

  // Index of the lowest clear bit; only meaningful when some bit is clear.
  function automatic logic [BIT_IX_W-1:0] first_zero(input logic [BYTE_W-1:0] b);
    logic [BIT_IX_W-1:0] f;
    f = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (!b[i]) f = BIT_IX_W'(i);
    end
    return f;
  endfunction

endpackage

// File: rtl/pfba_ctrl.sv
// Sequencing state machine of the page frame bitmap allocator.
// Depends on pfba_pkg; drives pfba_dp through command and status structs.
module pfba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_operation,
  output logic          in_stall,
  input  pfba_pkg::sts_t sts,
  output pfba_pkg::cmd_t cmd
);
  import pfba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_operation == OP_FREE) ? S_FREE_CHK : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_POST;
      end
      S_FREE_CHK: begin
        cmd.free_chk = 1'b1;
        state_nxt    = S_POST;
      end
      S_POST: begin
        // Wait for the output register to drain before handing over the result.
        if (!sts.out_busy) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// File: rtl/pfba_dp.sv
// Datapath of the page frame bitmap allocator: bound registers, bitmap memory,
// scan pointer, frame counter and output register. Depends on pfba_pkg.
module pfba_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfba_pkg::cmd_t                  cmd,
  output pfba_pkg::sts_t                  sts,
  input  logic                            cfg_we,
  input  logic [pfba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfba_pkg::ADDR_W-1:0]     cfg_data,
  input  logic [pfba_pkg::ADDR_W-1:0]     in_frame_address,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [pfba_pkg::ADDR_W-1:0]     out_granted_address,
  output logic [pfba_pkg::STATUS_W-1:0]   out_status,
  output logic [pfba_pkg::COUNT_W-1:0]    out_frames_in_use
);
  import pfba_pkg::*;

  logic [BYTE_W-1:0] mem [MAP_BYTES];

  logic [ADDR_W-1:0]   low_r, high_r;
  logic [MAP_AW-1:0]   clr_ptr_r;
  logic [MAP_AW-1:0]   ptr_r, rd_idx_r;
  logic                rd_live_r;
  logic [SB_W-1:0]     stop_r;
  logic                empty_r;
  logic [MAP_AW-1:0]   fbyte_r;
  logic [BIT_IX_W-1:0] fbit_r;
  logic                frange_r;
  logic [BYTE_W-1:0]   rdata_r;
  logic [COUNT_W-1:0]  count_r;
  logic [ADDR_W-1:0]   res_granted_r;
  status_t             res_status_r;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_granted_r;
  status_t             out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic [FRAME_W:0]    frame_lo;
  logic [SB_W-1:0]     start_byte, stop_raw, stop_clamp;
  logic [FRAME_W-1:0]  in_frame;
  logic                in_range_bad;
  logic [MAP_AW-1:0]   in_byte;
  logic [MAP_AW-1:0]   rd_addr;
  logic                hit, last, scan_done;
  logic [BIT_IX_W-1:0] zbit;
  logic                bit_set, alloc_wr, free_wr;
  logic                mem_we;
  logic [MAP_AW-1:0]   mem_waddr;
  logic [BYTE_W-1:0]   mem_wdata;

  // Bound registers. Reset restores the power-on window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= HIGH_BOUND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_BOUND:  low_r  <= cfg_data;
        REG_HIGH_BOUND: high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan window in bitmap bytes: the low bound rounds up to a frame, the high
  // bound rounds down, and the end is clamped to the size of the map.
  assign frame_lo   = {1'b0, low_r[ADDR_W-1:PAGE_SHIFT]}
                    + (FRAME_W+1)'(low_r[PAGE_SHIFT-1:0] != '0);
  assign start_byte = frame_lo[FRAME_W:BIT_IX_W];
  assign stop_raw   = SB_W'(high_r[ADDR_W-1:PAGE_SHIFT+BIT_IX_W]);
  assign stop_clamp = (stop_raw > SB_W'(MAP_BYTES)) ? SB_W'(MAP_BYTES) : stop_raw;

  assign in_frame     = in_frame_address[ADDR_W-1:PAGE_SHIFT];
  assign in_range_bad = {1'b0, in_frame} >= (FRAME_W+1)'(MAP_FRAMES);
  assign in_byte      = in_frame[BIT_IX_W +: MAP_AW];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ptr_r    <= start_byte[MAP_AW-1:0];
      stop_r   <= stop_clamp;
      empty_r  <= start_byte >= stop_clamp;
      fbyte_r  <= in_byte;
      fbit_r   <= in_frame[BIT_IX_W-1:0];
      frange_r <= in_range_bad;
    end else if (cmd.scan) begin
      ptr_r <= ptr_r + MAP_AW'(1);
    end
    if (cmd.scan) rd_idx_r <= ptr_r;
  end

  // The read data of an issued scan address is registered and shows up in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) rd_live_r <= 1'b0;
    else        rd_live_r <= cmd.scan;
  end

  assign rd_addr = cmd.scan ? ptr_r : in_byte;

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  assign hit       = rd_live_r && (rdata_r != BYTE_FULL);
  assign last      = rd_live_r && ((SB_W'(rd_idx_r) + SB_W'(1)) >= stop_r);
  assign scan_done = empty_r || hit || last;
  assign zbit      = first_zero(rdata_r);
  assign bit_set   = rdata_r[fbit_r];
  assign alloc_wr  = cmd.scan && hit;
  assign free_wr   = cmd.free_chk && !frange_r && bit_set;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx_r;
    mem_wdata = rdata_r | (BYTE_W'(1) << zbit);
    if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_ptr_r;
      mem_wdata = '0;
    end else if (alloc_wr) begin
      mem_we = 1'b1;
    end else if (free_wr) begin
      mem_we    = 1'b1;
      mem_waddr = fbyte_r;
      mem_wdata = rdata_r & ~(BYTE_W'(1) << fbit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)     clr_ptr_r <= '0;
    else if (cmd.clr) clr_ptr_r <= clr_ptr_r + MAP_AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        count_r <= '0;
    else if (alloc_wr) count_r <= count_r + COUNT_W'(1);
    else if (free_wr)  count_r <= count_r - COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && scan_done) begin
      if (hit) begin
        res_granted_r <= ADDR_W'({rd_idx_r, zbit, {PAGE_SHIFT{1'b0}}});
        res_status_r  <= ST_OK;
      end else begin
        res_granted_r <= '0;
        res_status_r  <= ST_OOM;
      end
    end else if (cmd.free_chk) begin
      res_granted_r <= '0;
      if (frange_r)      res_status_r <= ST_RANGE;
      else if (!bit_set) res_status_r <= ST_ALREADY_FREE;
      else               res_status_r <= ST_OK;
    end
  end

  assign out_valid_nxt = cmd.post || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_granted_r <= res_granted_r;
      out_status_r  <= res_status_r;
      out_count_r   <= count_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_granted_r;
  assign out_status          = out_status_r;
  assign out_frames_in_use   = out_count_r;

  assign sts.clr_last  = clr_ptr_r == MAP_AW'(MAP_BYTES - 1);
  assign sts.scan_done = scan_done;
  assign sts.out_busy  = out_valid_r && out_stall;

endmodule

// File: rtl/page_frame_bitmap_allocator.sv
// First-fit page frame allocator over a used-bit bitmap of 4 KiB frames, one
// request at a time. After reset the bitmap memory is swept to zero, one byte per
// cycle, with in_stall held high; configuration writes are taken at any time.
// An allocate request reads the bitmap memory, which has a separate read and
// write port, one byte per cycle from the low bound upward; in_stall stays high
// until the result is posted. The block takes the next request once the previous
// result enters the output register, which holds it for as long as out_stall is high.
module page_frame_bitmap_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [pfba_pkg::ADDR_W-1:0]    in_frame_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pfba_pkg::ADDR_W-1:0]    out_granted_address,
  output logic [pfba_pkg::STATUS_W-1:0]  out_status,
  output logic [pfba_pkg::COUNT_W-1:0]   out_frames_in_use,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfba_pkg::ADDR_W-1:0]    cfg_data
);
  import pfba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pfba_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  pfba_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_frame_address    (in_frame_address),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_granted_address (out_granted_address),
    .out_status          (out_status),
    .out_frames_in_use   (out_frames_in_use)
  );

endmodule

// File: rtl/pfba_chk.sv
// Port-level checker for the page frame bitmap allocator, bound to the top level.
// Depends on pfba_pkg.
module pfba_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [pfba_pkg::ADDR_W-1:0]    out_granted_address,
  input logic [pfba_pkg::STATUS_W-1:0]  out_status,
  input logic [pfba_pkg::COUNT_W-1:0]   out_frames_in_use
);
  import pfba_pkg::*;

  // A stalled result transaction stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted_address)
      && $stable(out_status) && $stable(out_frames_in_use))
    else $error("result changed while stalled");

  // Only a successful allocation returns an address.
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_address == '0)
    else $error("address returned with a failure status");

  // Granted addresses are frame aligned.
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_granted_address[PAGE_SHIFT-1:0] == '0)
    else $error("granted address not frame aligned");

  // The count never exceeds the number of frames in the map.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frames_in_use <= COUNT_W'(MAP_FRAMES))
    else $error("frames in use above map size");

endmodule

bind page_frame_bitmap_allocator pfba_chk u_pfba_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_granted_address (out_granted_address),
  .out_status          (out_status),
  .out_frames_in_use   (out_frames_in_use)
);

// File: tb/tb_page_frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_frame_bitmap_allocator: bound register writes,
// allocate and free transactions, and a frame map predictor that checks every result.
// Depends on pfba_pkg and the allocator RTL only.
module tb_page_frame_bitmap_allocator;
  import pfba_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int TARGET_ITEMS = 580;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
  } frame_req_t;

  typedef struct {
    logic [ADDR_W-1:0]  granted;
    status_t            status;
    logic [COUNT_W-1:0] in_use;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_operation = OP_ALLOC;
  logic [ADDR_W-1:0]    in_frame_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_W-1:0]    out_granted_address;
  logic [STATUS_W-1:0]  out_status;
  logic [COUNT_W-1:0]   out_frames_in_use;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOW_BOUND;
  logic [ADDR_W-1:0]    cfg_data = '0;

  page_frame_bitmap_allocator dut (.*);

  // Predictor state: our own copy of the frame map, the count and the bounds.
  logic [BYTE_W-1:0] used_bits [MAP_BYTES] = '{default: '0};
  int unsigned       used_frames = 0;
  logic [ADDR_W-1:0] bound_lo = '0;
  logic [ADDR_W-1:0] bound_hi = HIGH_BOUND_RESET;

  frame_req_t    pending_reqs[$];
  frame_result_t expected_results[$];
  frame_req_t    cur_req;
  int            gap_left = 0;
  int            stall_left = 0;
  int            quiet_cycles = 0;
  int            mismatches = 0;
  int            sent = 0;
  bit            idling = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // First-fit allocate or free against the predicted map; returns the result it causes.
  function automatic frame_result_t serve_request(input frame_req_t req);
    frame_result_t     res;
    longint unsigned   lo_frame;
    longint unsigned   start_byte;
    longint unsigned   stop_byte;
    longint unsigned   b;
    int unsigned       frame;
    logic              found;
    res.granted = '0;
    res.status  = ST_OK;
    found       = 1'b0;
    if (req.op == OP_ALLOC) begin
      lo_frame   = ({32'd0, bound_lo} + PAGE_BYTES - 1) / PAGE_BYTES;
      start_byte = lo_frame / BYTE_W;
      stop_byte  = ({32'd0, bound_hi} / PAGE_BYTES) / BYTE_W;
      if (stop_byte > MAP_BYTES) stop_byte = MAP_BYTES;
      for (b = start_byte; b < stop_byte && !found; b++) begin
        for (int i = 0; i < BYTE_W && !found; i++) begin
          if (!used_bits[b][i]) begin
            used_bits[b][i] = 1'b1;
            used_frames++;
            res.granted = ADDR_W'((b * BYTE_W + i) * PAGE_BYTES);
            found = 1'b1;
          end
        end
      end
      if (!found) res.status = ST_OOM;
    end else begin
      frame = req.addr >> PAGE_SHIFT;
      if (frame >= MAP_FRAMES) begin
        res.status = ST_RANGE;
      end else if (!used_bits[frame / BYTE_W][frame % BYTE_W]) begin
        res.status = ST_ALREADY_FREE;
      end else begin
        used_bits[frame / BYTE_W][frame % BYTE_W] = 1'b0;
        used_frames--;
      end
    end
    res.in_use = COUNT_W'(used_frames);
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] frame_addr(input int unsigned f);
    return ADDR_W'(f * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
  endfunction

  task automatic queue_alloc();
    frame_req_t r;
    r.op   = OP_ALLOC;
    r.addr = $urandom;
    pending_reqs.push_back(r);
    sent++;
  endtask

  task automatic queue_free(input logic [ADDR_W-1:0] addr);
    frame_req_t r;
    r.op   = OP_FREE;
    r.addr = addr;
    pending_reqs.push_back(r);
    sent++;
  endtask

  // Every request causes exactly one result, so an empty expectation store means idle.
  task automatic settle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_LOW_BOUND) bound_lo = val;
    else bound_hi = val;
  endtask

  // Request driver: the prediction is made at the edge where the transaction is taken.
  always @(posedge clk) begin
    logic held;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      held = 1'b0;
      if (in_valid && in_stall) held = 1'b1;
      else if (in_valid) expected_results.push_back(serve_request(cur_req));
      if (!held) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_operation     <= cur_req.op;
          in_frame_address <= cur_req.addr;
          held = 1'b1;
          gap_left = idling ? $urandom_range(0, 3) : 0;
        end
      end
      in_valid <= held;
    end
  end

  // Result monitor; the drawn stall only counts down while a result is waiting.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no request outstanding: granted_address 0x%08h",
                 out_granted_address);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_granted_address !== want.granted) begin
            $error("granted_address: expected 0x%08h, got 0x%08h",
                   want.granted, out_granted_address);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_frames_in_use !== want.in_use) begin
            $error("frames_in_use: expected %0d, got %0d", want.in_use, out_frames_in_use);
            mismatches++;
          end
        end
        stall_left = idling ? $urandom_range(0, 3) : 0;
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                kind;
    int                pick;
    int                phase_len;
    int                alloc_pct;
    int                sb;
    int                w;
    int                f;
    int                win_lo;
    int                win_hi;
    logic [ADDR_W-1:0] lo_val;
    logic [ADDR_W-1:0] hi_val;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Frame zero, double free and frees beyond the map under the reset bounds.
    queue_alloc();
    queue_alloc();
    queue_free(32'h0000_0FFF);
    queue_free(32'h0000_0000);
    queue_free(32'hFFFF_FFFF);
    queue_free(32'h0200_0000);
    queue_free(32'h01FF_FFFF);
    queue_alloc();
    queue_free(32'h0000_1ABC);
    settle();
    // A low bound at the top of the address space leaves an empty window.
    write_bound(REG_LOW_BOUND, '1);
    queue_alloc();
    settle();
    write_bound(REG_LOW_BOUND, '0);
    write_bound(REG_HIGH_BOUND, '0);
    queue_alloc();
    settle();
    // The scan starts at the byte holding the lowest frame, so frame 1 is still granted.
    write_bound(REG_LOW_BOUND, 32'd4097);
    write_bound(REG_HIGH_BOUND, '1);
    queue_alloc();
    queue_alloc();
    settle();
    // Fill the last map byte, run out, then free frames inside and outside the bounds.
    write_bound(REG_LOW_BOUND, 32'h01FF_8000);
    repeat (9) queue_alloc();
    queue_free(32'h01FF_F123);
    queue_alloc();
    queue_free(32'h0000_0000);
    queue_free(32'h0000_5000);

    while (sent < TARGET_ITEMS) begin
      settle();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        lo_val = $urandom_range(0, 65535);
        hi_val = $urandom_range(0, 1) ? '1 : HIGH_BOUND_RESET;
        win_lo = 0;
        win_hi = MAP_FRAMES - 1;
      end else if (kind == 1) begin
        lo_val = $urandom;
        hi_val = $urandom;
        win_lo = 0;
        win_hi = MAP_FRAMES - 1;
      end else begin
        sb = $urandom_range(0, MAP_BYTES - 1);
        w  = $urandom_range(1, 12);
        win_lo = sb * BYTE_W;
        win_hi = (sb + w) * BYTE_W - 1;
        if (win_hi > MAP_FRAMES - 1) win_hi = MAP_FRAMES - 1;
        f = win_lo + $urandom_range(0, BYTE_W - 1);
        lo_val = (f == 0) ? '0 : ADDR_W'(f * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1));
        hi_val = ADDR_W'(((sb + w) * BYTE_W + $urandom_range(0, BYTE_W - 1)) * PAGE_BYTES +
                         $urandom_range(0, PAGE_BYTES - 1));
      end
      write_bound(REG_LOW_BOUND, lo_val);
      write_bound(REG_HIGH_BOUND, hi_val);
      idling    = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(8, 40);
      alloc_pct = $urandom_range(25, 85);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          queue_alloc();
        end else begin
          pick = $urandom_range(0, 9);
          if (pick == 0) queue_free($urandom);
          else if (pick == 1) queue_free(frame_addr($urandom_range(0, MAP_FRAMES - 1)));
          else queue_free(frame_addr($urandom_range(win_lo, win_hi)));
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
